// ===== hdl/epce_pkg.sv =====
// shared types, constants and cordic angle table for the pose to extrinsics core
`default_nettype none
package epce_pkg;

    localparam int ATAN_LEN = 24;
    localparam int ZW = 34;                        // cordic angle/vector width, q2.30 plus guard
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] GAIN_Q30    = 34'sd652032874;

    typedef logic signed [ZW-1:0] cval_t;

    function automatic cval_t atan_q30(input logic [4:0] i);
        unique case (i)
            5'd0:    atan_q30 = 34'sh3243F6A8;
            5'd1:    atan_q30 = 34'sh1DAC6705;
            5'd2:    atan_q30 = 34'sh0FADBAFC;
            5'd3:    atan_q30 = 34'sh07F56EA6;
            5'd4:    atan_q30 = 34'sh03FEAB76;
            5'd5:    atan_q30 = 34'sh01FFD55B;
            5'd6:    atan_q30 = 34'sh00FFFAAA;
            5'd7:    atan_q30 = 34'sh007FFF55;
            5'd8:    atan_q30 = 34'sh003FFFEA;
            5'd9:    atan_q30 = 34'sh001FFFFD;
            5'd10:   atan_q30 = 34'sh000FFFFF;
            5'd11:   atan_q30 = 34'sh0007FFFF;
            5'd12:   atan_q30 = 34'sh0003FFFF;
            5'd13:   atan_q30 = 34'sh0001FFFF;
            5'd14:   atan_q30 = 34'sh0000FFFF;
            5'd15:   atan_q30 = 34'sh00007FFF;
            5'd16:   atan_q30 = 34'sh00003FFF;
            5'd17:   atan_q30 = 34'sh00001FFF;
            5'd18:   atan_q30 = 34'sh00000FFF;
            5'd19:   atan_q30 = 34'sh000007FF;
            5'd20:   atan_q30 = 34'sh000003FF;
            5'd21:   atan_q30 = 34'sh000001FF;
            5'd22:   atan_q30 = 34'sh000000FF;
            5'd23:   atan_q30 = 34'sh0000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

    // rounded q2.30 product: (a*b + 2^29) >>> 30
    function automatic cval_t mul30(input cval_t a, input cval_t b);
        logic signed [2*ZW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        mul30 = cval_t'(p >>> 30);
    endfunction

    // q2.30 to clamped q2.14
    function automatic logic signed [15:0] to_q14(input cval_t v);
        cval_t r;
        r = (v + 34'sd32768) >>> 16;
        if (r > 34'sd16384)
            to_q14 = 16'sd16384;
        else if (r < -34'sd16384)
            to_q14 = -16'sd16384;
        else
            to_q14 = r[15:0];
    endfunction

    typedef struct packed {
        logic        vld;
        logic [15:0] slot;
        logic        inv;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } tag_t;

endpackage
`default_nettype wire

// ===== hdl/epce_cordic.sv =====
// pipelined cordic: sin and cos of three angles, one step per stage
`default_nettype none
module epce_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire epce_pkg::tag_t tag_in,
    input  wire logic signed [15:0] ang_in [3],
    output epce_pkg::tag_t tag_out,
    output epce_pkg::cval_t sin_out [3],
    output epce_pkg::cval_t cos_out [3]
);
    import epce_pkg::*;

    localparam int N = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

    logic  vld_reg [N+1];
    tag_t  tag_reg [N+1];
    cval_t x_reg [N+1][3];
    cval_t y_reg [N+1][3];
    cval_t z_reg [N+1][3];
    logic  neg_reg [N+1][3];

    // stage 0: widen and fold into +-pi/2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= tag_in.vld;
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= tag_in;
        for (int a = 0; a < 3; a++)
        begin
            cval_t z;
            z = cval_t'(ang_in[a]) <<< 17;
            x_reg[0][a] <= GAIN_Q30;
            y_reg[0][a] <= '0;
            if (z > HALF_PI_Q30)
            begin
                z_reg[0][a]   <= z - PI_Q30;
                neg_reg[0][a] <= 1'b1;
            end
            else if (z < -HALF_PI_Q30)
            begin
                z_reg[0][a]   <= z + PI_Q30;
                neg_reg[0][a] <= 1'b1;
            end
            else
            begin
                z_reg[0][a]   <= z;
                neg_reg[0][a] <= 1'b0;
            end
        end
    end

    for (genvar s = 0; s < N; s++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            tag_reg[s+1] <= tag_reg[s];
            for (int a = 0; a < 3; a++)
            begin
                neg_reg[s+1][a] <= neg_reg[s][a];
                if (!z_reg[s][a][ZW-1])
                begin
                    x_reg[s+1][a] <= x_reg[s][a] - (y_reg[s][a] >>> s);
                    y_reg[s+1][a] <= y_reg[s][a] + (x_reg[s][a] >>> s);
                    z_reg[s+1][a] <= z_reg[s][a] - atan_q30(5'(s));
                end
                else
                begin
                    x_reg[s+1][a] <= x_reg[s][a] + (y_reg[s][a] >>> s);
                    y_reg[s+1][a] <= y_reg[s][a] - (x_reg[s][a] >>> s);
                    z_reg[s+1][a] <= z_reg[s][a] + atan_q30(5'(s));
                end
            end
        end
    end

    always_comb
    begin
        tag_out     = tag_reg[N];
        tag_out.vld = vld_reg[N];
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sin_out[a] = neg_reg[N][a] ? -y_reg[N][a] : y_reg[N][a];
            cos_out[a] = neg_reg[N][a] ? -x_reg[N][a] : x_reg[N][a];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/epce_matrix.sv =====
// rotation matrix and camera translation, registered stages
`default_nettype none
module epce_matrix (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire epce_pkg::tag_t tag_in,
    input  wire epce_pkg::cval_t sin_in [3],
    input  wire epce_pkg::cval_t cos_in [3],
    output epce_pkg::tag_t tag_out,
    output logic signed [15:0] rot_out [3][3],
    output logic signed [31:0] trn_out [3]
);
    import epce_pkg::*;

    logic  a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    // stage a: first level products
    tag_t  a_tag_reg;
    cval_t c3s2_reg, s3s2_reg, s3c1_reg, s3s1_reg, c3c1_reg, c3s1_reg;
    cval_t r00_reg, r10_reg, r20_reg, r21_reg, r22_reg;
    cval_t a_s1_reg, a_c1_reg;
    // stage b: full matrix
    tag_t  b_tag_reg;
    cval_t r_reg [3][3];
    // stage c: products with translation
    tag_t  c_tag_reg;
    logic signed [63:0] p_reg [3][3];
    logic signed [15:0] q14_reg [3][3];
    // stage d: sums
    tag_t  d_tag_reg;
    logic signed [15:0] q14d_reg [3][3];
    logic signed [31:0] tr_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= tag_in.vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [66:0] acc;
        logic signed [66:0] rs;
        a_tag_reg <= tag_in;
        c3s2_reg <= mul30(cos_in[2], sin_in[1]);
        s3s2_reg <= mul30(sin_in[2], sin_in[1]);
        s3c1_reg <= mul30(sin_in[2], cos_in[0]);
        s3s1_reg <= mul30(sin_in[2], sin_in[0]);
        c3c1_reg <= mul30(cos_in[2], cos_in[0]);
        c3s1_reg <= mul30(cos_in[2], sin_in[0]);
        r00_reg  <= mul30(cos_in[2], cos_in[1]);
        r10_reg  <= mul30(sin_in[2], cos_in[1]);
        r20_reg  <= -sin_in[1];
        r21_reg  <= mul30(cos_in[1], sin_in[0]);
        r22_reg  <= mul30(cos_in[1], cos_in[0]);
        a_s1_reg <= sin_in[0];
        a_c1_reg <= cos_in[0];

        b_tag_reg <= a_tag_reg;
        r_reg[0][0] <= r00_reg;
        r_reg[0][1] <= mul30(c3s2_reg, a_s1_reg) - s3c1_reg;
        r_reg[0][2] <= mul30(c3s2_reg, a_c1_reg) + s3s1_reg;
        r_reg[1][0] <= r10_reg;
        r_reg[1][1] <= mul30(s3s2_reg, a_s1_reg) + c3c1_reg;
        r_reg[1][2] <= mul30(s3s2_reg, a_c1_reg) - c3s1_reg;
        r_reg[2][0] <= r20_reg;
        r_reg[2][1] <= r21_reg;
        r_reg[2][2] <= r22_reg;

        c_tag_reg <= b_tag_reg;
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
            begin
                cval_t rq;
                rq = (r_reg[j][k] + 34'sd2) >>> 2;
                // rq fits 32 bits after the q2.28 rounding
                unique case (j)
                    0:       p_reg[j][k] <= 64'(signed'(rq[31:0])) * 64'(b_tag_reg.tx);
                    1:       p_reg[j][k] <= 64'(signed'(rq[31:0])) * 64'(b_tag_reg.ty);
                    default: p_reg[j][k] <= 64'(signed'(rq[31:0])) * 64'(b_tag_reg.tz);
                endcase
                q14_reg[j][k] <= to_q14(r_reg[j][k]);
            end

        d_tag_reg <= c_tag_reg;
        q14d_reg <= q14_reg;
        for (int k = 0; k < 3; k++)
        begin
            acc = 67'(p_reg[0][k]) + 67'(p_reg[1][k]) + 67'(p_reg[2][k]);
            rs  = -((acc + (67'sd1 <<< 27)) >>> 28);
            if (rs > 67'sd2147483647)
                tr_reg[k] <= 32'sh7FFFFFFF;
            else if (rs < -67'sd2147483648)
                tr_reg[k] <= 32'sh80000000;
            else
                tr_reg[k] <= rs[31:0];
        end
    end

    always_comb
    begin
        tag_out     = d_tag_reg;
        tag_out.vld = d_vld_reg;
    end
    assign rot_out = q14d_reg;
    assign trn_out = tr_reg;
endmodule
`default_nettype wire

// ===== hdl/euler_pose_to_camera_extrinsics_core.sv =====
// top level: pose to camera extrinsics with pipelined cordic and output sequencer
//
//  channel  | handshake       | ports
//  ---------+-----------------+------------------------------------------------
//  pose in  | start / busy    | position_index pose_id roll/pitch/yaw_angle pos_x/y/z
//  row out  | result_valid    | camera_slot invalid row_index rot_col0..2
//           |                 | cam_translation last
//
// a pose is taken only while busy is low; busy rises after each accepted start;
// a pose runs through the cordic stages (steps capped at 24), matrix stages a to d
// and the row sequencer to the first row; rows follow one per cycle.
// an invalid pose gives one row; busy still follows its start as for a valid pose.
// reset clears all valid bits; results cannot be stalled.
`default_nettype none
module euler_pose_to_camera_extrinsics_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic busy,
    input  wire logic [15:0] position_index,
    input  wire logic signed [15:0] pose_id,
    input  wire logic signed [15:0] roll_angle,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] yaw_angle,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    output logic result_valid,
    output logic [15:0] camera_slot,
    output logic invalid,
    output logic [1:0] row_index,
    output logic signed [15:0] rot_col0,
    output logic signed [15:0] rot_col1,
    output logic signed [15:0] rot_col2,
    output logic signed [31:0] cam_translation,
    output logic last
);
    import epce_pkg::*;

    logic [1:0] hold_reg;
    tag_t tag_in, tag_c, tag_m;
    logic signed [15:0] ang [3];
    cval_t sn [3], cs [3];
    logic signed [15:0] rot [3][3];
    logic signed [31:0] trn [3];

    logic [1:0] row_reg;
    logic active_reg;
    logic [15:0] slot_reg;
    logic inv_reg;
    logic signed [15:0] rot_reg [3][3];
    logic signed [31:0] trn_reg [3];

    assign busy = (hold_reg != 2'd0);

    always_comb
    begin
        tag_in.vld  = start && !busy;
        tag_in.inv  = pose_id[15];
        tag_in.slot = pose_id[15] ? position_index : pose_id;
        tag_in.tx   = pos_x;
        tag_in.ty   = pos_y;
        tag_in.tz   = pos_z;
        ang[0] = roll_angle;
        ang[1] = pitch_angle;
        ang[2] = yaw_angle;
    end

    epce_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .tag_in(tag_in), .ang_in(ang),
        .tag_out(tag_c), .sin_out(sn), .cos_out(cs)
    );

    epce_matrix u_matrix (
        .clk(clk), .rst_n(rst_n), .tag_in(tag_c), .sin_in(sn), .cos_in(cs),
        .tag_out(tag_m), .rot_out(rot), .trn_out(trn)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 2'd0;
            active_reg <= 1'b0;
            row_reg    <= 2'd0;
        end
        else
        begin
            if (tag_in.vld)
                hold_reg <= 2'd2;
            else if (hold_reg != 2'd0)
                hold_reg <= hold_reg - 2'd1;
            if (tag_m.vld)
            begin
                active_reg <= 1'b1;
                row_reg    <= 2'd0;
            end
            else if (active_reg && (row_reg == 2'd2 || inv_reg))
                active_reg <= 1'b0;
            else if (active_reg)
                row_reg <= row_reg + 2'd1;
        end
    end

    // capture one item's matrix, then walk its rows
    always_ff @(posedge clk)
    begin
        if (tag_m.vld)
        begin
            slot_reg <= tag_m.slot;
            inv_reg  <= tag_m.inv;
            rot_reg  <= rot;
            trn_reg  <= trn;
        end
    end

    always_comb
    begin
        result_valid = active_reg;
        camera_slot  = slot_reg;
        invalid      = inv_reg;
        row_index    = inv_reg ? 2'd0 : row_reg;
        last         = inv_reg || (row_reg == 2'd2);
        rot_col0     = 16'sd0;
        rot_col1     = 16'sd0;
        rot_col2     = 16'sd0;
        cam_translation = 32'sd0;
        if (!inv_reg)
        begin
            unique case (row_reg)
                2'd0:
                begin
                    rot_col0 = rot_reg[0][0]; rot_col1 = rot_reg[1][0];
                    rot_col2 = rot_reg[2][0]; cam_translation = trn_reg[0];
                end
                2'd1:
                begin
                    rot_col0 = rot_reg[0][1]; rot_col1 = rot_reg[1][1];
                    rot_col2 = rot_reg[2][1]; cam_translation = trn_reg[1];
                end
                default:
                begin
                    rot_col0 = rot_reg[0][2]; rot_col1 = rot_reg[1][2];
                    rot_col2 = rot_reg[2][2]; cam_translation = trn_reg[2];
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        tag_m.vld |-> !active_reg || row_reg == 2'd2 || inv_reg)
        else $error("new item overran row walk");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 busy)
        else $error("busy window too short");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid || row_index == 2'd0)
        else $error("row after last");
endmodule
`default_nettype wire
